[hdl/c8_pkg.sv]
// Shared types, codes and helpers for the CHIP-8 instruction core
package c8_pkg;

  // Sizes
  localparam int MEM_BYTES   = 4096;
  localparam int MEM_AW      = $clog2(MEM_BYTES);
  localparam int STACK_DEPTH = 16;
  localparam int STK_AW      = $clog2(STACK_DEPTH);
  localparam int STK_LW      = $clog2(STACK_DEPTH + 1);
  localparam int SCR_W       = 64;
  localparam int SCR_H       = 32;
  localparam int ROW_AW      = $clog2(SCR_H);

  localparam logic [12:0] PROG_BASE = 13'h200;
  localparam logic [15:0] FONT_BASE = 16'h0050;
  // last pc at which an instruction can still be fetched is below this
  localparam logic [12:0] PC_LAST   = 13'(MEM_BYTES - 1);

  // Actions
  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_EXEC = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } act_t;

  // Fault codes
  localparam logic [1:0] FLT_NONE      = 2'd0;
  localparam logic [1:0] FLT_RET_EMPTY = 2'd1;
  localparam logic [1:0] FLT_CALL_FULL = 2'd2;

  // Opcode high nibbles
  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SEQ  = 4'h3;
  localparam logic [3:0] OP_SNE  = 4'h4;
  localparam logic [3:0] OP_SEQR = 4'h5;
  localparam logic [3:0] OP_LD   = 4'h6;
  localparam logic [3:0] OP_ADD  = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_JPV  = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEY  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  // 8XYN sub-operations
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  // Low-byte codes
  localparam logic [7:0] SYS_CLS  = 8'hE0;
  localparam logic [7:0] SYS_RET  = 8'hEE;
  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;
  localparam logic [7:0] FX_GDLY  = 8'h07;
  localparam logic [7:0] FX_WKEY  = 8'h0A;
  localparam logic [7:0] FX_SDLY  = 8'h15;
  localparam logic [7:0] FX_SSND  = 8'h18;
  localparam logic [7:0] FX_ADDI  = 8'h1E;
  localparam logic [7:0] FX_FONT  = 8'h29;
  localparam logic [7:0] FX_BCD   = 8'h33;
  localparam logic [7:0] FX_STORE = 8'h55;
  localparam logic [7:0] FX_LOAD  = 8'h65;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_ROW_RD, S_ROW_Q,
    S_F_HI, S_F_LO, S_F_VX, S_F_VY, S_EXEC, S_VF,
    S_BCD0, S_BCD1, S_BCD2,
    S_ST_RD, S_ST_WR, S_LD_RD, S_LD_WR,
    S_DR_RD, S_DR_WR, S_FIN, S_DONE
  } st_t;

  // Decoded effects of one instruction
  typedef struct packed {
    logic [12:0] pc;
    logic        v_we;
    logic [7:0]  v_data;
    logic        f;
    logic        idx_we;
    logic [15:0] idx;
    logic        dly_we;
    logic        snd_we;
    logic        push;
    logic        pop;
    logic        clr;
    logic [1:0]  fault;
    logic        wait_k;
    logic        chg;
    st_t         nst;
  } ex_t;

  // Decimal digits {hundreds, tens, ones} of a byte
  function automatic logic [11:0] bcd3(input logic [7:0] v);
    logic [3:0]  h;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  t;
    logic [3:0]  o;
    h    = (v >= 8'd200) ? 4'd2 : ((v >= 8'd100) ? 4'd1 : 4'd0);
    rem  = 7'(v - ({4'h0, h} * 8'd100));
    // rem / 10 by reciprocal, exact for rem below 100
    prod = 15'(rem) * 15'd205;
    t    = 4'(prod >> 11);
    o    = 4'(rem - ({3'b000, t} * 7'd10));
    return {h, t, o};
  endfunction

endpackage

[hdl/c8_ram.sv]
// Simple dual-port synchronous RAM, registered read
module c8_ram #(
  parameter int AW = 12,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/chip8_instruction_core_unit.sv]
// Items are handled one at a time: in_ready is high only while idle, and a new item
//   is taken only after the previous result has entered the output register.
// An execute item with pc at or above PC_LAST is reported as halted without a fetch.
// The sequencer works around the byte-wide main memory and register-file ports.
// Reset (rst_n low, synchronous): pc 0x200, registers, timers, display cleared.
module chip8_instruction_core_unit import c8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [15:0] in_key_mask,
  input  logic        in_key_press_valid,
  input  logic [3:0]  in_key_press_code,
  input  logic [7:0]  in_random_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_row_pixels,
  output logic [12:0] out_program_counter,
  output logic        out_halted,
  output logic        out_sound_active,
  output logic        out_collision,
  output logic        out_display_changed,
  output logic        out_waiting_key,
  output logic [1:0]  out_fault
);

  st_t st_r, st_nxt;

  // captured item
  act_t        act_r;
  logic [11:0] addr_r;
  logic [7:0]  data_r;
  logic [15:0] keys_r;
  logic        kpv_r;
  logic [3:0]  kpc_r;
  logic [7:0]  rnd_r;

  // architectural state outside the memories
  logic [12:0]       pc_r, next_r;
  logic [15:0]       idx_r;
  logic [7:0]        dly_r, snd_cnt_r;
  logic [STK_LW-1:0] lvl_r;
  logic [12:0]       stk_r [STACK_DEPTH];
  logic [15:0]       vvld_r;
  logic [SCR_H-1:0]  dvld_r;

  // working registers
  logic [7:0] hi_r, lo_r, vx_r, vy_r;
  logic       f_r;
  logic [3:0] cnt_r;
  logic       vok_r, dok_r;

  // result being built
  logic [63:0] row_r;
  logic        coll_r, chg_r, wait_r, snd_r;
  logic [1:0]  fault_r;

  // output register
  logic        out_valid_r;
  logic [63:0] out_row_r;
  logic [12:0] out_pc_r;
  logic        out_halt_r, out_snd_r, out_coll_r, out_chg_r, out_wait_r;
  logic [1:0]  out_fault_r;

  // memory ports
  logic              m_we;
  logic [MEM_AW-1:0] m_waddr, m_raddr;
  logic [7:0]        m_wdata, m_rdata;
  logic              v_we;
  logic [3:0]        v_waddr, v_raddr;
  logic [7:0]        v_wdata, v_rdata;
  logic              d_we;
  logic [ROW_AW-1:0] d_waddr, d_raddr;
  logic [SCR_W-1:0]  d_wdata, d_rdata;

  c8_ram #(.AW(MEM_AW), .DW(8)) u_mem (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  c8_ram #(.AW(4), .DW(8)) u_vreg (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  c8_ram #(.AW(ROW_AW), .DW(SCR_W)) u_disp (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  // instruction fields
  logic [3:0]  op, xr, yr, nr;
  logic [11:0] nnn;
  logic [7:0]  vy_w, vq_w;
  logic        accept;
  logic        out_free;

  assign op       = hi_r[7:4];
  assign xr       = hi_r[3:0];
  assign yr       = lo_r[7:4];
  assign nr       = lo_r[3:0];
  assign nnn      = {xr, lo_r};
  assign vq_w     = vok_r ? v_rdata : 8'h00;
  assign vy_w     = vq_w;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // stack pointers
  logic [STK_LW-1:0] lvl_m1;
  assign lvl_m1 = lvl_r - STK_LW'(1);

  // loop address off the index register, wraps with the memory
  logic [MEM_AW-1:0] idx_off;
  assign idx_off = idx_r[MEM_AW-1:0] + MEM_AW'(cnt_r);

  // sprite row handling
  logic [8:0]       row_y;
  logic             row_on;
  logic [7:0]       spr_rev;
  logic [SCR_W-1:0] mask, row_old;
  assign row_y   = {1'b0, vy_r} + {5'b0, cnt_r};
  assign row_on  = row_y < 9'(SCR_H);
  assign row_old = dok_r ? d_rdata : '0;

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      spr_rev[c] = m_rdata[7-c];
    end
  end

  // columns past the right edge fall off the shift
  assign mask = (vx_r >= 8'(SCR_W)) ? '0 : ({56'b0, spr_rev} << vx_r[5:0]);

  logic [11:0] digits;
  assign digits = bcd3(vx_r);

  logic key_hit;
  assign key_hit = (vx_r < 8'd16) && keys_r[vx_r[3:0]];

  // Instruction decode
  ex_t  ex;
  logic [8:0] sum9;
  assign sum9 = {1'b0, vx_r} + {1'b0, vy_w};

  always_comb begin
    ex        = '0;
    ex.pc     = pc_r + 13'd2;
    ex.fault  = FLT_NONE;
    ex.nst    = S_FIN;
    unique case (op)
      OP_SYS: begin
        if (xr == 4'h0 && lo_r == SYS_CLS) begin
          ex.clr = 1'b1;
          ex.chg = 1'b1;
        end else if (xr == 4'h0 && lo_r == SYS_RET) begin
          if (lvl_r == '0) begin
            ex.fault = FLT_RET_EMPTY;
          end else begin
            ex.pop = 1'b1;
            ex.pc  = stk_r[lvl_m1[STK_AW-1:0]] + 13'd2;
          end
        end
      end
      OP_JP: ex.pc = {1'b0, nnn};
      OP_CALL: begin
        if (lvl_r >= STK_LW'(STACK_DEPTH)) begin
          ex.fault = FLT_CALL_FULL;
        end else begin
          ex.push = 1'b1;
          ex.pc   = {1'b0, nnn};
        end
      end
      OP_SEQ:  if (vx_r == lo_r) ex.pc = pc_r + 13'd4;
      OP_SNE:  if (vx_r != lo_r) ex.pc = pc_r + 13'd4;
      OP_SEQR: if (vx_r == vy_w) ex.pc = pc_r + 13'd4;
      OP_LD: begin
        ex.v_we   = 1'b1;
        ex.v_data = lo_r;
      end
      OP_ADD: begin
        ex.v_we   = 1'b1;
        ex.v_data = vx_r + lo_r;
      end
      OP_ALU: begin
        ex.v_we = 1'b1;
        case (nr)
          ALU_MOV: ex.v_data = vy_w;
          ALU_OR:  ex.v_data = vx_r | vy_w;
          ALU_AND: ex.v_data = vx_r & vy_w;
          ALU_XOR: ex.v_data = vx_r ^ vy_w;
          ALU_ADD: begin
            ex.v_data = sum9[7:0];
            ex.f      = sum9[8];
            ex.nst    = S_VF;
          end
          ALU_SUB: begin
            ex.v_data = vx_r - vy_w;
            ex.f      = vx_r >= vy_w;
            ex.nst    = S_VF;
          end
          ALU_SHR: begin
            ex.v_data = {1'b0, vx_r[7:1]};
            ex.f      = vx_r[0];
            ex.nst    = S_VF;
          end
          ALU_SBN: begin
            // flag from the old Vx
            ex.v_data = vy_w - vx_r;
            ex.f      = vy_w >= vx_r;
            ex.nst    = S_VF;
          end
          ALU_SHL: begin
            ex.v_data = {vx_r[6:0], 1'b0};
            ex.f      = vx_r[7];
            ex.nst    = S_VF;
          end
          default: ex.v_we = 1'b0;
        endcase
      end
      OP_SNER: if (nr == 4'h0 && vx_r != vy_w) ex.pc = pc_r + 13'd4;
      OP_LDI: begin
        ex.idx_we = 1'b1;
        ex.idx    = {4'h0, nnn};
      end
      // vx holds V0 for this form
      OP_JPV: ex.pc = {5'b0, vx_r} + {1'b0, nnn};
      OP_RND: begin
        ex.v_we   = 1'b1;
        ex.v_data = rnd_r & lo_r;
      end
      OP_DRW: begin
        ex.chg = 1'b1;
        ex.nst = S_DR_RD;
      end
      OP_KEY: begin
        if (lo_r == KEY_SKP && key_hit) ex.pc = pc_r + 13'd4;
        else if (lo_r == KEY_SKNP && !key_hit) ex.pc = pc_r + 13'd4;
      end
      default: begin
        case (lo_r)
          FX_GDLY: begin
            ex.v_we   = 1'b1;
            ex.v_data = dly_r;
          end
          FX_WKEY: begin
            if (kpv_r) begin
              ex.v_we   = 1'b1;
              ex.v_data = {4'h0, kpc_r};
            end else begin
              ex.wait_k = 1'b1;
              ex.pc     = pc_r;
            end
          end
          FX_SDLY: ex.dly_we = 1'b1;
          FX_SSND: ex.snd_we = 1'b1;
          FX_ADDI: begin
            ex.idx_we = 1'b1;
            ex.idx    = idx_r + {8'h00, vx_r};
          end
          FX_FONT: begin
            ex.idx_we = 1'b1;
            ex.idx    = FONT_BASE + {6'h00, vx_r, 2'b00} + {8'h00, vx_r};
          end
          FX_BCD:   ex.nst = S_BCD0;
          FX_STORE: ex.nst = S_ST_RD;
          FX_LOAD:  ex.nst = S_LD_RD;
          default: ;
        endcase
      end
    endcase
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (act_t'(in_action))
            ACT_LOAD: st_nxt = S_LOAD;
            ACT_EXEC: st_nxt = (pc_r >= PC_LAST) ? S_DONE : S_F_HI;
            ACT_READ: st_nxt = S_ROW_RD;
            ACT_NONE: st_nxt = S_DONE;
          endcase
        end
      end
      S_LOAD:   st_nxt = S_DONE;
      S_ROW_RD: st_nxt = S_ROW_Q;
      S_ROW_Q:  st_nxt = S_DONE;
      S_F_HI:   st_nxt = S_F_LO;
      S_F_LO:   st_nxt = S_F_VX;
      S_F_VX:   st_nxt = S_F_VY;
      S_F_VY:   st_nxt = S_EXEC;
      S_EXEC:   st_nxt = ex.nst;
      S_VF:     st_nxt = S_FIN;
      S_BCD0:   st_nxt = S_BCD1;
      S_BCD1:   st_nxt = S_BCD2;
      S_BCD2:   st_nxt = S_FIN;
      S_ST_RD:  st_nxt = S_ST_WR;
      S_ST_WR:  st_nxt = (cnt_r == xr) ? S_FIN : S_ST_RD;
      S_LD_RD:  st_nxt = S_LD_WR;
      S_LD_WR:  st_nxt = (cnt_r == xr) ? S_FIN : S_LD_RD;
      S_DR_RD:  st_nxt = (cnt_r == nr) ? S_VF : S_DR_WR;
      S_DR_WR:  st_nxt = S_DR_RD;
      S_FIN:    st_nxt = S_DONE;
      S_DONE:   st_nxt = out_free ? S_IDLE : S_DONE;
      default:  st_nxt = S_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    m_we    = 1'b0;
    m_waddr = idx_off;
    m_wdata = 8'h00;
    m_raddr = idx_off;
    v_we    = 1'b0;
    v_waddr = xr;
    v_wdata = 8'h00;
    v_raddr = cnt_r;
    d_we    = 1'b0;
    d_waddr = row_y[ROW_AW-1:0];
    d_wdata = row_old ^ mask;
    d_raddr = row_y[ROW_AW-1:0];
    unique case (st_r)
      S_LOAD: begin
        m_we    = 1'b1;
        m_waddr = addr_r;
        m_wdata = data_r;
      end
      S_ROW_RD: d_raddr = addr_r[ROW_AW-1:0];
      S_F_HI:   m_raddr = pc_r[MEM_AW-1:0];
      S_F_LO:   m_raddr = pc_r[MEM_AW-1:0] + MEM_AW'(1);
      S_F_VX:   v_raddr = (op == OP_JPV) ? 4'h0 : xr;
      S_F_VY:   v_raddr = yr;
      S_EXEC: begin
        v_we    = ex.v_we;
        v_wdata = ex.v_data;
      end
      S_VF: begin
        v_we    = 1'b1;
        v_waddr = 4'hF;
        v_wdata = {7'b0, f_r};
      end
      S_BCD0: begin
        m_we    = 1'b1;
        m_waddr = idx_r[MEM_AW-1:0];
        m_wdata = {4'h0, digits[11:8]};
      end
      S_BCD1: begin
        m_we    = 1'b1;
        m_waddr = idx_r[MEM_AW-1:0] + MEM_AW'(1);
        m_wdata = {4'h0, digits[7:4]};
      end
      S_BCD2: begin
        m_we    = 1'b1;
        m_waddr = idx_r[MEM_AW-1:0] + MEM_AW'(2);
        m_wdata = {4'h0, digits[3:0]};
      end
      S_ST_WR: begin
        m_we    = 1'b1;
        m_wdata = vq_w;
      end
      S_LD_WR: begin
        v_we    = 1'b1;
        v_waddr = cnt_r;
        v_wdata = m_rdata;
      end
      S_DR_WR: d_we = row_on;
      default: ;
    endcase
  end

  assign in_ready = (st_r == S_IDLE);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      pc_r        <= PROG_BASE;
      idx_r       <= '0;
      dly_r       <= '0;
      snd_cnt_r   <= '0;
      lvl_r       <= '0;
      vvld_r      <= '0;
      dvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (v_we) vvld_r[v_waddr] <= 1'b1;
      if (st_r == S_EXEC && ex.clr) dvld_r <= '0;
      else if (d_we) dvld_r[d_waddr] <= 1'b1;
      if (st_r == S_EXEC) begin
        if (ex.idx_we) idx_r <= ex.idx;
        if (ex.dly_we) dly_r <= vx_r;
        if (ex.snd_we) snd_cnt_r <= vx_r;
        if (ex.push) lvl_r <= lvl_r + STK_LW'(1);
        else if (ex.pop) lvl_r <= lvl_m1;
      end
      // timers tick after the instruction
      if (st_r == S_FIN) begin
        pc_r <= next_r;
        if (dly_r != 8'h00) dly_r <= dly_r - 8'd1;
        if (snd_cnt_r != 8'h00) snd_cnt_r <= snd_cnt_r - 8'd1;
      end
      if (st_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    vok_r <= vvld_r[v_raddr];
    dok_r <= dvld_r[d_raddr];
    if (accept) begin
      act_r   <= act_t'(in_action);
      addr_r  <= in_address;
      data_r  <= in_data;
      keys_r  <= in_key_mask;
      kpv_r   <= in_key_press_valid;
      kpc_r   <= in_key_press_code;
      rnd_r   <= in_random_byte;
      row_r   <= '0;
      coll_r  <= 1'b0;
      chg_r   <= 1'b0;
      wait_r  <= 1'b0;
      fault_r <= FLT_NONE;
      snd_r   <= (snd_cnt_r != 8'h00);
    end
    unique case (st_r)
      S_ROW_Q: row_r <= (act_r == ACT_READ && dok_r) ? d_rdata : '0;
      S_F_LO:  hi_r <= m_rdata;
      S_F_VX:  lo_r <= m_rdata;
      S_F_VY:  vx_r <= vq_w;
      S_EXEC: begin
        vy_r    <= vy_w;
        next_r  <= ex.pc;
        f_r     <= ex.f;
        fault_r <= ex.fault;
        wait_r  <= ex.wait_k;
        chg_r   <= ex.chg;
        cnt_r   <= 4'h0;
        if (ex.push) stk_r[lvl_r[STK_AW-1:0]] <= pc_r;
      end
      S_ST_WR, S_LD_WR: cnt_r <= cnt_r + 4'd1;
      S_DR_RD: if (cnt_r == nr) f_r <= coll_r;
      S_DR_WR: begin
        cnt_r <= cnt_r + 4'd1;
        if (row_on && |(row_old & mask)) coll_r <= 1'b1;
      end
      S_FIN: snd_r <= (snd_cnt_r != 8'h00);
      S_DONE: begin
        if (out_free) begin
          out_row_r   <= row_r;
          out_pc_r    <= pc_r;
          out_halt_r  <= (pc_r >= PC_LAST);
          out_snd_r   <= snd_r;
          out_coll_r  <= coll_r;
          out_chg_r   <= chg_r;
          out_wait_r  <= wait_r;
          out_fault_r <= fault_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_row_pixels      = out_row_r;
  assign out_program_counter = out_pc_r;
  assign out_halted          = out_halt_r;
  assign out_sound_active    = out_snd_r;
  assign out_collision       = out_coll_r;
  assign out_display_changed = out_chg_r;
  assign out_waiting_key     = out_wait_r;
  assign out_fault           = out_fault_r;

endmodule

[hdl/c8_checker.sv]
// Port-level checks on the core's result channel
module c8_checker import c8_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [12:0] out_program_counter,
  input logic        out_halted,
  input logic        out_collision,
  input logic        out_display_changed,
  input logic        out_waiting_key,
  input logic [1:0]  out_fault
);

  // a stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_program_counter))
    else $error("result changed while stalled");

  // halted flag follows the reported pc
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_halted == (out_program_counter >= PC_LAST))
    else $error("halted flag disagrees with pc");

  // collision only from a draw
  a_coll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_collision |-> out_display_changed)
    else $error("collision without display change");

  // wait-for-key neither draws nor faults
  a_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_waiting_key |-> !out_display_changed && out_fault == FLT_NONE)
    else $error("waiting item with side effects");

  a_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fault == FLT_NONE || out_fault == FLT_RET_EMPTY ||
                  out_fault == FLT_CALL_FULL)
    else $error("unknown fault code");

endmodule

bind chip8_instruction_core_unit c8_checker u_c8_checker (.*);
